### src/lso_pkg.sv
package lso_pkg;

  localparam int COORD_BITS      = 20;
  localparam int COORD_FRAC_BITS = 8;
  localparam int FRACTION_BITS   = 16;
  localparam int TOL_BITS        = 12;
  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(256);

  // Differences of two coordinates.
  localparam int DIFF_BITS = COORD_BITS + 1;
  // Dot products and squared lengths in the general case.
  localparam int DOT_BITS  = 2 * DIFF_BITS + 1;
  // Unsigned magnitude width used by the divider.
  localparam int MAG_BITS  = DOT_BITS;
  // Quotient: integer part 0..2 plus fraction bits.
  localparam int QUO_BITS  = FRACTION_BITS + 2;
  // Signed lambda in [-1.0, 2.0].
  localparam int LAM_BITS  = FRACTION_BITS + 3;
  localparam int OUT_BITS  = FRACTION_BITS + 1;
  // One quotient bit per divider stage: the integer bit plus fraction bits.
  localparam int DIV_STEPS = FRACTION_BITS + 1;

  typedef enum logic [1:0] {
    CASE_VERT  = 2'd0,
    CASE_HORIZ = 2'd1,
    CASE_GEN   = 2'd2
  } line_case_t;

  // Per-item control that travels alongside the divider data.
  typedef struct packed {
    line_case_t lcase;
    logic       degen;
  } item_ctl_t;

endpackage

### src/lso_if.sv
interface lso_in_if;
  import lso_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] obs_start_x;
  logic signed [COORD_BITS-1:0] obs_start_y;
  logic signed [COORD_BITS-1:0] obs_end_x;
  logic signed [COORD_BITS-1:0] obs_end_y;
  logic signed [COORD_BITS-1:0] proj_start_x;
  logic signed [COORD_BITS-1:0] proj_start_y;
  logic signed [COORD_BITS-1:0] proj_end_x;
  logic signed [COORD_BITS-1:0] proj_end_y;
  modport source (output valid, obs_start_x, obs_start_y, obs_end_x, obs_end_y,
                  proj_start_x, proj_start_y, proj_end_x, proj_end_y, input ready);
  modport sink (input valid, obs_start_x, obs_start_y, obs_end_x, obs_end_y,
                proj_start_x, proj_start_y, proj_end_x, proj_end_y, output ready);
endinterface

interface lso_out_if;
  import lso_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] overlap_fraction;
  logic [1:0]          line_case;
  logic                degenerate;
  modport source (output valid, overlap_fraction, line_case, degenerate, input ready);
  modport sink (input valid, overlap_fraction, line_case, degenerate, output ready);
endinterface

interface lso_cfg_if;
  import lso_pkg::*;
  logic                valid;
  logic                ready;
  logic [TOL_BITS-1:0] axis_tolerance;
  modport source (output valid, axis_tolerance, input ready);
  modport sink (input valid, axis_tolerance, output ready);
endinterface

### src/lso_div_stage.sv
// One restoring-division step on both lambdas of an item.
module lso_div_stage
  import lso_pkg::*;
(
  input  logic                clk,
  input  logic                adv,
  input  logic [MAG_BITS-1:0] den_i,
  input  logic [MAG_BITS:0]   rem_s_i,
  input  logic [MAG_BITS:0]   rem_e_i,
  input  logic [QUO_BITS-1:0] q_s_i,
  input  logic [QUO_BITS-1:0] q_e_i,
  output logic [MAG_BITS-1:0] den_o,
  output logic [MAG_BITS:0]   rem_s_o,
  output logic [MAG_BITS:0]   rem_e_o,
  output logic [QUO_BITS-1:0] q_s_o,
  output logic [QUO_BITS-1:0] q_e_o
);

  logic [MAG_BITS:0] den_w;
  logic [MAG_BITS:0] rem_s_nxt, rem_e_nxt;
  logic              bit_s, bit_e;

  always_comb begin
    den_w = {1'b0, den_i};
    bit_s = rem_s_i >= den_w;
    bit_e = rem_e_i >= den_w;
    rem_s_nxt = bit_s ? rem_s_i - den_w : rem_s_i;
    rem_e_nxt = bit_e ? rem_e_i - den_w : rem_e_i;
  end

  // The remainder stays below den, so one left shift fits in MAG_BITS+1 bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      den_o   <= den_i;
      rem_s_o <= {rem_s_nxt[MAG_BITS-1:0], 1'b0};
      rem_e_o <= {rem_e_nxt[MAG_BITS-1:0], 1'b0};
      q_s_o   <= {q_s_i[QUO_BITS-2:0], bit_s};
      q_e_o   <= {q_e_i[QUO_BITS-2:0], bit_e};
    end
  end

endmodule

### src/lso_front.sv
// Front end: case selection, differences, products and dot products.
// Three register stages, all advancing on adv.
module lso_front
  import lso_pkg::*;
(
  input  logic                        clk,
  input  logic                        adv,
  input  logic [TOL_BITS-1:0]         tol,
  input  logic signed [COORD_BITS-1:0] sx, sy, ex, ey, psx, psy, pex, pey,
  output item_ctl_t                   ctl_o,
  output logic [MAG_BITS-1:0]         den_o,
  output logic [MAG_BITS-1:0]         num_s_o,
  output logic [MAG_BITS-1:0]         num_e_o,
  output logic                        neg_s_o,
  output logic                        neg_e_o
);

  typedef logic signed [DIFF_BITS-1:0] diff_t;
  typedef logic signed [DOT_BITS-1:0]  dot_t;

  // Stage 1: differences and case.
  diff_t      lx_r, ly_r, dsx_r, dsy_r, dex_r, dey_r;
  line_case_t case_r;
  diff_t      lx_nxt, ly_nxt;
  logic [DIFF_BITS-1:0] alx, aly;

  always_comb begin
    lx_nxt = DIFF_BITS'(ex) - DIFF_BITS'(sx);
    ly_nxt = DIFF_BITS'(ey) - DIFF_BITS'(sy);
    alx = lx_nxt[DIFF_BITS-1] ? -lx_nxt : lx_nxt;
    aly = ly_nxt[DIFF_BITS-1] ? -ly_nxt : ly_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r  <= lx_nxt;
      ly_r  <= ly_nxt;
      dsx_r <= DIFF_BITS'(psx) - DIFF_BITS'(sx);
      dsy_r <= DIFF_BITS'(psy) - DIFF_BITS'(sy);
      dex_r <= DIFF_BITS'(pex) - DIFF_BITS'(sx);
      dey_r <= DIFF_BITS'(pey) - DIFF_BITS'(sy);
      if (alx < DIFF_BITS'(tol)) begin
        case_r <= CASE_VERT;
      end else if (aly < DIFF_BITS'(tol)) begin
        case_r <= CASE_HORIZ;
      end else begin
        case_r <= CASE_GEN;
      end
    end
  end

  // Stage 2: products. Axis cases pass the plain differences.
  dot_t       p_sx_r, p_sy_r, p_ex_r, p_ey_r, p_lx_r, p_ly_r;
  line_case_t case2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      case2_r <= case_r;
      case (case_r)
        CASE_VERT: begin
          p_sx_r <= DOT_BITS'(dsy_r); p_sy_r <= '0;
          p_ex_r <= DOT_BITS'(dey_r); p_ey_r <= '0;
          p_lx_r <= DOT_BITS'(ly_r);  p_ly_r <= '0;
        end
        CASE_HORIZ: begin
          p_sx_r <= DOT_BITS'(dsx_r); p_sy_r <= '0;
          p_ex_r <= DOT_BITS'(dex_r); p_ey_r <= '0;
          p_lx_r <= DOT_BITS'(lx_r);  p_ly_r <= '0;
        end
        default: begin
          p_sx_r <= DOT_BITS'(dsx_r) * DOT_BITS'(lx_r);
          p_sy_r <= DOT_BITS'(dsy_r) * DOT_BITS'(ly_r);
          p_ex_r <= DOT_BITS'(dex_r) * DOT_BITS'(lx_r);
          p_ey_r <= DOT_BITS'(dey_r) * DOT_BITS'(ly_r);
          p_lx_r <= DOT_BITS'(lx_r) * DOT_BITS'(lx_r);
          p_ly_r <= DOT_BITS'(ly_r) * DOT_BITS'(ly_r);
        end
      endcase
    end
  end

  // Stage 3: sums, signs and magnitudes.
  dot_t ns, ne, dd;
  always_comb begin
    ns = p_sx_r + p_sy_r;
    ne = p_ex_r + p_ey_r;
    dd = p_lx_r + p_ly_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_o.lcase <= case2_r;
      ctl_o.degen <= dd == '0;
      neg_s_o <= ns[DOT_BITS-1] != dd[DOT_BITS-1];
      neg_e_o <= ne[DOT_BITS-1] != dd[DOT_BITS-1];
      num_s_o <= ns[DOT_BITS-1] ? MAG_BITS'(-ns) : MAG_BITS'(ns);
      num_e_o <= ne[DOT_BITS-1] ? MAG_BITS'(-ne) : MAG_BITS'(ne);
      den_o   <= dd[DOT_BITS-1] ? MAG_BITS'(-dd) : MAG_BITS'(dd);
    end
  end

endmodule

### src/lso_back.sv
// Saturation flag stage, divider pipeline and the clipping stage.
module lso_back
  import lso_pkg::*;
(
  input  logic                clk,
  input  logic                adv,
  input  item_ctl_t           ctl_i,
  input  logic [MAG_BITS-1:0] den_i,
  input  logic [MAG_BITS-1:0] num_s_i,
  input  logic [MAG_BITS-1:0] num_e_i,
  input  logic                neg_s_i,
  input  logic                neg_e_i,
  output item_ctl_t           ctl_o,
  output logic [OUT_BITS-1:0] frac_o
);

  localparam int NST = DIV_STEPS + 1;
  localparam logic signed [LAM_BITS-1:0] ONE = LAM_BITS'(1) <<< FRACTION_BITS;

  // Entry stage: detect quotients of two or more.
  logic [MAG_BITS:0]   den2;
  logic [MAG_BITS-1:0] den_a [NST];
  logic [MAG_BITS:0]   rs_a  [NST];
  logic [MAG_BITS:0]   re_a  [NST];
  logic [QUO_BITS-1:0] qs_a  [NST];
  logic [QUO_BITS-1:0] qe_a  [NST];
  item_ctl_t           ctl_a [NST];
  logic                ns_a  [NST];
  logic                ne_a  [NST];
  logic                ss_a  [NST];
  logic                se_a  [NST];

  assign den2 = {den_i, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      den_a[0] <= den_i;
      rs_a[0]  <= {1'b0, num_s_i};
      re_a[0]  <= {1'b0, num_e_i};
      qs_a[0]  <= '0;
      qe_a[0]  <= '0;
      ctl_a[0] <= ctl_i;
      ns_a[0]  <= neg_s_i;
      ne_a[0]  <= neg_e_i;
      ss_a[0]  <= {1'b0, num_s_i} >= den2;
      se_a[0]  <= {1'b0, num_e_i} >= den2;
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    lso_div_stage u_stage (
      .clk(clk), .adv(adv),
      .den_i(den_a[g]), .rem_s_i(rs_a[g]), .rem_e_i(re_a[g]),
      .q_s_i(qs_a[g]), .q_e_i(qe_a[g]),
      .den_o(den_a[g+1]), .rem_s_o(rs_a[g+1]), .rem_e_o(re_a[g+1]),
      .q_s_o(qs_a[g+1]), .q_e_o(qe_a[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_a[g+1] <= ctl_a[g];
        ns_a[g+1]  <= ns_a[g];
        ne_a[g+1]  <= ne_a[g];
        ss_a[g+1]  <= ss_a[g];
        se_a[g+1]  <= se_a[g];
      end
    end
  end

  function automatic logic signed [LAM_BITS-1:0] to_lambda(
    input logic [QUO_BITS-1:0] q, input logic sat, input logic neg);
    logic [QUO_BITS-1:0] m;
    m = sat ? QUO_BITS'(2) << FRACTION_BITS : q;
    if (neg) begin
      if (m > QUO_BITS'(1) << FRACTION_BITS) m = QUO_BITS'(1) << FRACTION_BITS;
      return -LAM_BITS'(m);
    end
    return LAM_BITS'(m);
  endfunction

  logic signed [LAM_BITS-1:0] ls, le, lo, hi, ov;

  always_comb begin
    ls = to_lambda(qs_a[NST-1], ss_a[NST-1], ns_a[NST-1]);
    le = to_lambda(qe_a[NST-1], se_a[NST-1], ne_a[NST-1]);
    lo = (ls < le) ? ls : le;
    hi = (ls < le) ? le : ls;
    if (ctl_a[NST-1].degen) begin
      ov = '0;
    end else if (lo < 0 && hi > ONE) begin
      ov = ONE;
    end else if (hi < 0 || lo > ONE) begin
      ov = '0;
    end else if (lo < 0) begin
      ov = hi;
    end else if (hi > ONE) begin
      ov = ONE - lo;
    end else begin
      ov = hi - lo;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_o  <= ctl_a[NST-1];
      frac_o <= ov[OUT_BITS-1:0];
    end
  end

endmodule

### src/line_segment_overlap_unit.sv
// Throughput: one item per cycle while the sink takes results; the 17-stage
// restoring divider, one quotient bit per stage, sets the depth, and every stage
// advances together.
// Reset (rst_n low, synchronous) clears all valid bits and returns
// axis_tolerance to 256; payload registers are not reset.
module line_segment_overlap_unit
  import lso_pkg::*;
(
  input logic clk,
  input logic rst_n,
  lso_in_if.sink    in_ch,
  lso_out_if.source out_ch,
  lso_cfg_if.sink   cfg_ch
);

  // Front end 3 stages, divider entry 1, divider 17, clip 1.
  localparam int DEPTH = 3 + 1 + DIV_STEPS + 1;

  logic [TOL_BITS-1:0] tol_r;
  logic [DEPTH-1:0]    vld_r;
  logic                adv;

  // The whole pipeline moves as one; it stalls only when the last stage holds
  // a result that the sink does not take. Holes in the pipe are not squeezed out.
  assign adv          = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        tol_r <= cfg_ch.axis_tolerance;
      end
      if (adv) begin
        vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
      end
    end
  end

  item_ctl_t           f_ctl, b_ctl;
  logic [MAG_BITS-1:0] f_den, f_ns, f_ne;
  logic                f_neg_s, f_neg_e;
  logic [OUT_BITS-1:0] b_frac;

  lso_front u_front (
    .clk(clk), .adv(adv), .tol(tol_r),
    .sx(in_ch.obs_start_x), .sy(in_ch.obs_start_y),
    .ex(in_ch.obs_end_x), .ey(in_ch.obs_end_y),
    .psx(in_ch.proj_start_x), .psy(in_ch.proj_start_y),
    .pex(in_ch.proj_end_x), .pey(in_ch.proj_end_y),
    .ctl_o(f_ctl), .den_o(f_den), .num_s_o(f_ns), .num_e_o(f_ne),
    .neg_s_o(f_neg_s), .neg_e_o(f_neg_e)
  );

  lso_back u_back (
    .clk(clk), .adv(adv), .ctl_i(f_ctl), .den_i(f_den),
    .num_s_i(f_ns), .num_e_i(f_ne), .neg_s_i(f_neg_s), .neg_e_i(f_neg_e),
    .ctl_o(b_ctl), .frac_o(b_frac)
  );

  assign out_ch.valid            = vld_r[DEPTH-1];
  assign out_ch.overlap_fraction = b_frac;
  assign out_ch.line_case        = b_ctl.lcase;
  assign out_ch.degenerate       = b_ctl.degen;

endmodule

### src/lso_checker.sv
module lso_checker
  import lso_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] overlap_fraction,
  input logic [1:0]          line_case,
  input logic                degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(overlap_fraction))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> overlap_fraction <= (OUT_BITS'(1) << FRACTION_BITS))
    else $error("fraction above one");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> overlap_fraction == '0)
    else $error("degenerate item with nonzero fraction");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  a_case: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_case != 2'd3)
    else $error("bad line case");

endmodule

bind line_segment_overlap_unit lso_checker u_lso_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .overlap_fraction(out_ch.overlap_fraction),
  .line_case(out_ch.line_case), .degenerate(out_ch.degenerate)
);

### tb/sv/line_segment_overlap_unit_test.sv
`timescale 1ns / 1ps

module line_segment_overlap_unit_test;
  import lso_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One segment pair, in port order: observed start/end, projected start/end.
  typedef struct {
    coord_t osx, osy, oex, oey;
    coord_t psx, psy, pex, pey;
  } seg_pair_t;

  typedef struct {
    logic [OUT_BITS-1:0] frac;
    line_case_t          lcase;
    logic                degen;
  } overlap_t;

  localparam longint UNIT       = longint'(1) << FRACTION_BITS;
  localparam int     DRAIN_WAIT = 40;
  localparam int     LIMIT      = 600000;

  logic clk;
  logic rst_n;

  lso_in_if  in_ch ();
  lso_out_if out_ch ();
  lso_cfg_if cfg_ch ();

  line_segment_overlap_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Items waiting to be offered, and the results still owed by the block.
  seg_pair_t pairs_to_send[$];
  overlap_t  overlaps_owed[$];
  seg_pair_t offered;

  // The tolerance the block currently holds, as the checker sees it.
  logic [TOL_BITS-1:0] tol_now;

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int errors;
  int items_sent;
  int overlaps_checked;
  int degen_seen;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor of the overlap arithmetic.
  // ---------------------------------------------------------------------------

  // Signed quotient num/den in Q.16. The magnitude is truncated, then the
  // result is saturated to [-1.0, 2.0]. The caller guarantees den != 0.
  function automatic longint lambda_q16(longint num, longint den);
    logic   neg;
    longint r;
    longint d;
    longint q;
    neg = (num < 0) != (den < 0);
    r   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    if (r >= 2 * d) begin
      q = 2 * UNIT;
    end else begin
      q = 0;
      if (r >= d) begin
        r = r - d;
        q = 1;
      end
      for (int i = 0; i < FRACTION_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
    end
    if (neg) begin
      if (q > UNIT) q = UNIT;
      return -q;
    end
    return q;
  endfunction

  function automatic overlap_t predict_overlap(seg_pair_t p, logic [TOL_BITS-1:0] tol);
    overlap_t o;
    longint   lx;
    longint   ly;
    longint   len2;
    longint   l0;
    longint   l1;
    longint   lo;
    longint   hi;
    longint   amt;
    longint   tl;
    lx  = longint'(p.oex) - longint'(p.osx);
    ly  = longint'(p.oey) - longint'(p.osy);
    tl  = longint'(tol);
    l0  = 0;
    l1  = 0;
    amt = 0;
    o.degen = 1'b0;
    // Vertical wins over horizontal when both differences are small.
    if ((lx < 0 ? -lx : lx) < tl) begin
      o.lcase = CASE_VERT;
      if (ly == 0) o.degen = 1'b1;
      else begin
        l0 = lambda_q16(longint'(p.psy) - longint'(p.osy), ly);
        l1 = lambda_q16(longint'(p.pey) - longint'(p.osy), ly);
      end
    end else if ((ly < 0 ? -ly : ly) < tl) begin
      o.lcase = CASE_HORIZ;
      if (lx == 0) o.degen = 1'b1;
      else begin
        l0 = lambda_q16(longint'(p.psx) - longint'(p.osx), lx);
        l1 = lambda_q16(longint'(p.pex) - longint'(p.osx), lx);
      end
    end else begin
      // Orthogonal projection onto the observed line. The coordinates are
      // narrow enough that no pre-scaling of the differences is needed.
      o.lcase = CASE_GEN;
      len2    = lx * lx + ly * ly;
      if (len2 == 0) o.degen = 1'b1;
      else begin
        l0 = lambda_q16((longint'(p.psx) - longint'(p.osx)) * lx +
                        (longint'(p.psy) - longint'(p.osy)) * ly, len2);
        l1 = lambda_q16((longint'(p.pex) - longint'(p.osx)) * lx +
                        (longint'(p.pey) - longint'(p.osy)) * ly, len2);
      end
    end
    if (!o.degen) begin
      lo = (l0 < l1) ? l0 : l1;
      hi = (l0 < l1) ? l1 : l0;
      if (lo < 0 && hi > UNIT) amt = UNIT;
      else if (hi < 0 || lo > UNIT) amt = 0;
      else if (lo < 0) amt = hi;
      else if (hi > UNIT) amt = UNIT - lo;
      else amt = hi - lo;
    end
    o.frac = amt[OUT_BITS-1:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, with random gaps. An item counts as sent at
  // the edge where valid and ready are both high; its result is predicted then.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        overlaps_owed.push_back(predict_overlap(offered, tol_now));
        items_sent++;
      end
      if (pairs_to_send.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        offered = pairs_to_send.pop_front();
        in_ch.obs_start_x  <= offered.osx;
        in_ch.obs_start_y  <= offered.osy;
        in_ch.obs_end_x    <= offered.oex;
        in_ch.obs_end_y    <= offered.oey;
        in_ch.proj_start_x <= offered.psx;
        in_ch.proj_start_y <= offered.psy;
        in_ch.proj_end_x   <= offered.pex;
        in_ch.proj_end_y   <= offered.pey;
        in_ch.valid        <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: takes results, checks them in order, and throttles ready. A hold
  // request from the stimulus process starts a long stretch of ready low so
  // that the pipeline fills and pushes back on the input side.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    overlap_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (overlaps_owed.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          want = overlaps_owed.pop_front();
          overlaps_checked++;
          if (out_ch.degenerate) degen_seen++;
          if (out_ch.overlap_fraction !== want.frac)
            report("overlap_fraction", out_ch.overlap_fraction, want.frac);
          if (out_ch.line_case !== want.lcase)
            report("line_case", out_ch.line_case, want.lcase);
          if (out_ch.degenerate !== want.degen)
            report("degenerate", out_ch.degenerate, want.degen);
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen    <= hold_requests;
        hold_left    <= 300;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycles, overlaps_owed.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic seg_pair_t pair_of(longint a, longint b, longint c, longint d,
                                        longint e, longint f, longint g, longint h);
    seg_pair_t p;
    p.osx = coord_t'(a);  p.osy = coord_t'(b);
    p.oex = coord_t'(c);  p.oey = coord_t'(d);
    p.psx = coord_t'(e);  p.psy = coord_t'(f);
    p.pex = coord_t'(g);  p.pey = coord_t'(h);
    return p;
  endfunction

  function automatic longint spread(longint m);
    return longint'($urandom_range(32'(2 * m), 0)) - m;
  endfunction

  // A magnitude in [lo, hi] with a random sign.
  function automatic longint signed_mag(longint lo, longint hi);
    longint m;
    m = longint'($urandom_range(32'(hi), 32'(lo)));
    return $urandom_range(1, 0) ? -m : m;
  endfunction

  // Builds a pair of the given shape for the current tolerance: 0 vertical,
  // 1 horizontal, 2 general, 3 zero-length vertical, anything else raw bits.
  // Projected endpoints land near the observed line at about -0.51 .. 1.13 of its
  // length so that every clipping branch is hit.
  function automatic seg_pair_t shaped_pair(int shape, logic [TOL_BITS-1:0] tol);
    longint sx, sy, lx, ly, small_max, big_min, t0, t1;
    sx        = spread(200000);
    sy        = spread(200000);
    small_max = (tol > 0) ? longint'(tol) - 1 : 0;
    big_min   = (tol > 0) ? longint'(tol) : 1;
    case (shape)
      0: begin
        lx = spread(small_max);
        ly = signed_mag(1, 120000);
      end
      1: begin
        lx = signed_mag(big_min, 120000);
        ly = spread(small_max);
      end
      2: begin
        lx = signed_mag(big_min, 120000);
        ly = signed_mag(big_min, 120000);
        if ($urandom_range(3, 0) == 0) begin
          lx = signed_mag(big_min, big_min + 40);
          ly = signed_mag(big_min, big_min + 40);
        end
      end
      3: begin
        lx = spread(small_max);
        ly = 0;
      end
      default: begin
        return pair_of($urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom(), $urandom());
      end
    endcase
    t0 = longint'($urandom_range(420, 0)) - 130;
    t1 = longint'($urandom_range(420, 0)) - 130;
    return pair_of(sx, sy, sx + lx, sy + ly,
                   sx + (t0 * lx) / 256 + spread(40), sy + (t0 * ly) / 256 + spread(40),
                   sx + (t1 * lx) / 256 + spread(40), sy + (t1 * ly) / 256 + spread(40));
  endfunction

  function automatic int random_shape();
    int r;
    r = $urandom_range(99, 0);
    if (r < 28) return 0;
    if (r < 56) return 1;
    if (r < 84) return 2;
    if (r < 89) return 3;
    return 4;
  endfunction

  // Waits at falling edges until the block holds nothing, then lets the
  // pipeline's latency pass with some margin.
  task automatic drain();
    @(negedge clk);
    while (pairs_to_send.size() > 0 || in_ch.valid || overlaps_owed.size() > 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] value);
    drain();
    @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.axis_tolerance <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tol_now = value;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(negedge clk);
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      @(negedge clk);
      pairs_to_send.push_back(shaped_pair(random_shape(), tol_now));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  logic [TOL_BITS-1:0] tol_plan[6];

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.obs_start_x     = '0;
    in_ch.obs_start_y     = '0;
    in_ch.obs_end_x       = '0;
    in_ch.obs_end_y       = '0;
    in_ch.proj_start_x    = '0;
    in_ch.proj_start_y    = '0;
    in_ch.proj_end_x      = '0;
    in_ch.proj_end_y      = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.axis_tolerance = '0;
    tol_now               = TOL_RESET;
    sender_idle_pct       = 0;
    recv_stall_pct        = 0;
    hold_requests         = 0;
    errors                = 0;
    items_sent            = 0;
    overlaps_checked      = 0;
    degen_seen            = 0;
    cycles                = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset tolerance. The first two use the largest and
    // the smallest coordinate; both collapse to a zero-length vertical line.
    @(negedge clk);
    pairs_to_send.push_back(pair_of(524287, 524287, 524287, 524287,
                                    524287, 524287, 524287, 524287));
    pairs_to_send.push_back(pair_of(-524288, -524288, -524288, -524288,
                                    -524288, -524288, -524288, -524288));
    // Full-range diagonal, projected onto itself and then reversed.
    pairs_to_send.push_back(pair_of(-524288, -524288, 524287, 524287,
                                    -524288, -524288, 524287, 524287));
    pairs_to_send.push_back(pair_of(524287, -524288, -524288, 524287,
                                    -524288, 524287, 524287, -524288));
    // Vertical line: exact cover, span beyond both ends, wholly before,
    // wholly after, over the start, over the end, reversed inside.
    pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, 0, 0, 1000));
    pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, -500, 0, 1500));
    pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, -500, 0, -100));
    pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, 1200, 0, 2000));
    pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, -500, 0, 500));
    pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, 500, 0, 1500));
    pairs_to_send.push_back(pair_of(100, 0, 0, -1000, 0, -700, 0, -200));
    // Quotients far outside the saturation range on both sides.
    pairs_to_send.push_back(pair_of(0, 0, 0, 3, 0, -524288, 0, 524287));
    pairs_to_send.push_back(pair_of(0, 0, 0, -3, 0, 524287, 0, 524287));
    // Horizontal line, including a tiny y offset just under the tolerance.
    pairs_to_send.push_back(pair_of(0, 0, 4000, 255, 1000, 9, 3000, -9));
    pairs_to_send.push_back(pair_of(0, 0, -4000, 0, 1000, 0, -5000, 0));
    pairs_to_send.push_back(pair_of(0, 0, 4000, -255, 5000, 0, 4100, 0));
    // Vertical with zero length, and both differences at the tolerance.
    pairs_to_send.push_back(pair_of(50, 70, 300, 70, 0, 0, 9, 9));
    pairs_to_send.push_back(pair_of(0, 0, 256, 256, 0, 0, 256, 256));
    pairs_to_send.push_back(pair_of(0, 0, -256, 256, 128, 0, -300, 300));
    // General lines with projections off the line.
    pairs_to_send.push_back(pair_of(0, 0, 3000, 4000, 4000, -3000, 3000, 9000));
    pairs_to_send.push_back(pair_of(-1000, 500, 2000, -2500, 0, 0, -9000, 9000));

    // Phase tolerances: reset value first, then the extremes and others.
    tol_plan[0] = TOL_RESET;
    tol_plan[1] = '0;
    tol_plan[2] = '1;
    tol_plan[3] = TOL_BITS'(1);
    tol_plan[4] = TOL_BITS'($urandom_range(4095, 0));
    tol_plan[5] = TOL_BITS'($urandom_range(600, 2));

    for (int ph = 0; ph < 6; ph++) begin
      write_tolerance(tol_plan[ph]);
      if (ph == 1) begin
        // With no tolerance every line is general; a point line is degenerate.
        @(negedge clk);
        pairs_to_send.push_back(pair_of(7, 7, 7, 7, 0, 0, 100, 100));
        pairs_to_send.push_back(pair_of(0, 0, 0, 1000, 0, 0, 0, 600));
        pairs_to_send.push_back(pair_of(0, 0, 1, 0, -1, 0, 2, 0));
      end
      if (ph == 0) begin
        // Back-pressure: stop taking results while items keep coming.
        @(negedge clk);
        hold_requests = hold_requests + 1;
      end
      set_idling(0, 0);
      queue_random(67);
      drain();
      set_idling(72, 0);
      queue_random(67);
      drain();
      set_idling(0, 72);
      queue_random(67);
      drain();
      set_idling(37, 37);
      queue_random(67);
    end

    drain();
    $display("Covered %0d segment pairs over six tolerance settings, %0d results checked,",
             items_sent, overlaps_checked);
    $display("%0d of them degenerate, with idle and stall phases and one long hold.",
             degen_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/lso_pkg.sv
src/lso_if.sv
src/lso_div_stage.sv
src/lso_front.sv
src/lso_back.sv
src/line_segment_overlap_unit.sv
src/lso_checker.sv
tb/sv/line_segment_overlap_unit_test.sv
